// File: hdl/kthl_pkg.sv
// Shared constants and types for the streaming k-th largest selector.
package kthl_pkg;

  // Number of kept entries (cells in the chain)
  localparam int MAX_RANK = 16;
  localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int VAL_W    = 32;
  localparam int RANK_W   = 5;

  // Reset value of the rank register
  localparam logic [RANK_W-1:0] RANK_RST = RANK_W'(1);

  // What one cell hands to the cell below it
  typedef struct packed {
    logic                    take;   // new value lands at or above this cell
    logic                    valid;  // cell holds an entry
    logic signed [VAL_W-1:0] value;  // entry held
  } kthl_link_t;

  // Next contents of a cell, for the result select
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } kthl_entry_t;

endpackage

// File: hdl/streaming_kth_largest_top.sv
// Top level of the streaming k-th largest selector: cell chain and ports.
//
// Accepts one signed 32-bit value per clock cycle while the output register
// is free or draining, and returns one registered result per value. The
// largest values of the current set sit in a chain of kthl_pkg::MAX_RANK cells
// kept in descending order; every cell compares the incoming value against
// its entry in the same cycle and either holds, takes the value, or takes its
// upper neighbor's entry, so insertion needs no search, whatever the position.
// The result carries the rank-th largest value (0 while fewer than rank
// values have arrived) with the enough flag on out_tuser. Rank 0 reads as
// 1 and a rank above the chain length reads as the last cell. An input with
// tlast ends the set: the chain empties right after that result. Input is
// taken whenever the output register is empty or being drained. Rank is
// written through cfg_* and should only change while no request is pending.
module streaming_kth_largest_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kthl_pkg::RANK_W-1:0]       cfg_data,    // rank
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kthl_pkg::VAL_W-1:0]        in_tdata,    // [31:0] value
  input  logic                              in_tlast,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kthl_pkg::VAL_W-1:0]        out_tdata,   // [31:0] kth_value
  output logic                              out_tuser    // [0] enough
);

  logic [kthl_pkg::RANK_W-1:0]        rank_r;
  logic [kthl_pkg::IDX_W-1:0]         ridx;
  logic                               in_acc;
  logic signed [kthl_pkg::VAL_W-1:0]  new_val;
  kthl_pkg::kthl_link_t               link  [0:kthl_pkg::MAX_RANK];
  kthl_pkg::kthl_entry_t              entry [0:kthl_pkg::MAX_RANK-1];
  logic [kthl_pkg::MAX_RANK-1:0]      valid_vec;
  logic                               res_enough;
  logic [kthl_pkg::VAL_W-1:0]         res_kth;
  logic                               out_valid_r;
  logic [kthl_pkg::VAL_W-1:0]         out_kth_r;
  logic                               out_enough_r;

  // Rank register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= kthl_pkg::RANK_RST;
    end else if (cfg_valid && cfg_ready) begin
      rank_r <= cfg_data;
    end
  end

  // Clamp rank to the chain and turn it into a cell index
  always_comb begin
    if (rank_r == '0) begin
      ridx = '0;
    end else if (int'(rank_r) > kthl_pkg::MAX_RANK) begin
      ridx = kthl_pkg::IDX_W'(kthl_pkg::MAX_RANK - 1);
    end else begin
      ridx = kthl_pkg::IDX_W'(rank_r - kthl_pkg::RANK_W'(1));
    end
  end

  // Accept when the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign new_val   = $signed(in_tdata);

  // Chain of cells; the top cell has no neighbor above
  assign link[0] = '0;

  for (genvar i = 0; i < kthl_pkg::MAX_RANK; i++) begin : g_cell
    kthl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (in_acc),
      .clr     (in_tlast),
      .new_val (new_val),
      .up      (link[i]),
      .down    (link[i+1]),
      .nxt     (entry[i])
    );
    assign valid_vec[i] = link[i+1].valid;
  end

  // Pick the rank-th entry of the updated list
  assign res_enough = entry[ridx].valid;
  assign res_kth    = res_enough ? entry[ridx].value : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_kth_r    <= res_kth;
      out_enough_r <= res_enough;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_kth_r;
  assign out_tuser  = out_enough_r;

  // Occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + kthl_pkg::MAX_RANK'(1))) == '0))
    else $error("cell valid bits are not a prefix");

  // End of set empties the chain
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (valid_vec == '0))
    else $error("chain not emptied after last request");

  // Any other accepted request leaves the top cell occupied
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tlast) |=> valid_vec[0])
    else $error("top cell empty after insertion");

  // Every accepted request yields a pending result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("result missing after accepted request");

  // Rank one always has an answer once a value is in
  a_rank1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (ridx == '0)) |=> out_enough_r)
    else $error("maximum not reported as enough");

endmodule

// File: hdl/kthl_cell.sv
// One cell of the sorted chain: holds one entry, compares and shifts.
module kthl_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,       // request accepted
  input  logic                              clr,      // end of set
  input  logic signed [kthl_pkg::VAL_W-1:0] new_val,  // value being inserted
  input  kthl_pkg::kthl_link_t              up,       // from the cell above
  output kthl_pkg::kthl_link_t              down,     // to the cell below
  output kthl_pkg::kthl_entry_t             nxt       // contents after insert
);

  logic                              valid_r;
  logic signed [kthl_pkg::VAL_W-1:0] value_r;
  logic                              take;

  // Take the value if this slot is empty or the value beats the entry
  assign take = !valid_r || (new_val > value_r);

  assign down.take  = take;
  assign down.valid = valid_r;
  assign down.value = value_r;

  // Shift down from above, insert here, or hold
  always_comb begin
    nxt.valid = valid_r;
    nxt.value = value_r;
    if (take) begin
      if (up.take) begin
        nxt.valid = up.valid;
        nxt.value = up.value;
      end else begin
        nxt.valid = 1'b1;
        nxt.value = new_val;
      end
    end
  end

  // Entry register; value needs no reset since invalid entries are never read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= clr ? 1'b0 : nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= nxt.value;
    end
  end

endmodule

// File: tb/streaming_kth_largest_top_tb.sv
// Self-checking testbench for the streaming k-th largest selector.
`timescale 1ns / 1ps

module streaming_kth_largest_top_tb;

  // One expected result: k-th largest value and the enough flag
  typedef struct {
    logic signed [kthl_pkg::VAL_W-1:0] kth_value;
    logic                              enough;
  } kth_result_t;

  // Top-k predictor and queue of expected results
  class kth_scoreboard;
    logic signed [kthl_pkg::VAL_W-1:0] top_list [kthl_pkg::MAX_RANK];
    int                                seen_count;
    logic [kthl_pkg::RANK_W-1:0]       rank_q;
    kth_result_t                       expected_q[$];
    int                                errors;

    function new();
      foreach (top_list[i]) top_list[i] = '0;
      seen_count = 0;
      rank_q     = kthl_pkg::RANK_RST;
      errors     = 0;
    endfunction

    function void set_rank(logic [kthl_pkg::RANK_W-1:0] r);
      rank_q = r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Insert the value, predict the result, clear on the last request of a set
    function void note_input(logic signed [kthl_pkg::VAL_W-1:0] v, logic last);
      int          eff;
      int          n;
      int          pos;
      int          i;
      kth_result_t res;
      eff = (rank_q == 0) ? 1 :
            ((rank_q > kthl_pkg::MAX_RANK) ? kthl_pkg::MAX_RANK : int'(rank_q));
      n   = (seen_count > kthl_pkg::MAX_RANK) ? kthl_pkg::MAX_RANK : seen_count;
      pos = 0;
      // Equal values go below the kept entries equal to them
      while (pos < n && !(v > top_list[pos])) pos++;
      if (pos < kthl_pkg::MAX_RANK) begin
        i = (n < kthl_pkg::MAX_RANK) ? n : kthl_pkg::MAX_RANK - 1;
        while (i > pos) begin
          top_list[i] = top_list[i-1];
          i--;
        end
        top_list[pos] = v;
      end
      if (seen_count < kthl_pkg::MAX_RANK) seen_count++;
      res.enough    = (seen_count >= eff);
      res.kth_value = res.enough ? top_list[eff-1] : '0;
      expected_q.push_back(res);
      if (last) begin
        foreach (top_list[k]) top_list[k] = '0;
        seen_count = 0;
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic signed [kthl_pkg::VAL_W-1:0] kth, logic enough);
      kth_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: kth_value %0d enough %0b",
                 $time, kth, enough);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (kth !== exp_r.kth_value) begin
        $display("%0t: kth_value mismatch: expected %0d, actual %0d",
                 $time, exp_r.kth_value, kth);
        errors++;
      end
      if (enough !== exp_r.enough) begin
        $display("%0t: enough mismatch: expected %0b, actual %0b",
                 $time, exp_r.enough, enough);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [kthl_pkg::RANK_W-1:0]   cfg_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [kthl_pkg::VAL_W-1:0]    in_tdata;
  logic                          in_tlast;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [kthl_pkg::VAL_W-1:0]    out_tdata;
  logic                          out_tuser;

  kth_scoreboard sb = new();

  int snd_idle;
  int rcv_idle;
  int set_left;

  streaming_kth_largest_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Randomly stall the result side
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Sample handshakes mid-cycle, where all signals are settled for the next edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_rank(cfg_data);
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Offer one value; return at the edge where it is taken
  task automatic send_value(input logic [kthl_pkg::VAL_W-1:0] v, input logic last);
    logic ok;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Drain all results, then write the rank register
  task automatic write_rank(input logic [kthl_pkg::RANK_W-1:0] r);
    logic ok;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  // Random value: full range, narrow range for duplicates, or extremes
  function automatic logic [kthl_pkg::VAL_W-1:0] gen_value();
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return kthl_pkg::VAL_W'(int'($urandom_range(0, 15)) - 8);
      7:          return {1'b1, 31'($urandom_range(0, 3))};
      8:          return {1'b0, ~31'($urandom_range(0, 3))};
      default:    return $urandom & 32'h8000_00ff;
    endcase
  endfunction

  // Random sets of random length; sets may span a rank change
  task automatic send_random(input int count);
    repeat (count) begin
      if (set_left == 0) begin
        set_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24)
                                              : $urandom_range(25, 60);
      end
      send_value(gen_value(), set_left == 1);
      set_left--;
    end
  endtask

  initial begin
    logic [kthl_pkg::RANK_W-1:0] phase_rank [7];
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    snd_idle  = 28;
    rcv_idle  = 62;
    set_left  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset rank: extremes of the value field
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'hffff_ffff, 1'b1);

    // Rank zero reads as the maximum
    write_rank(5'd0);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b1);

    // Equal values and not-yet-enough results
    write_rank(5'd3);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(-32'sd3, 1'b1);

    // Rank above the chain length; full list drops a small value
    write_rank(5'd31);
    for (int i = 0; i < kthl_pkg::MAX_RANK; i++) begin
      send_value(kthl_pkg::VAL_W'(i * 3 - 20), 1'b0);
    end
    send_value(-32'sd100, 1'b1);

    phase_rank[0] = 5'd16;
    phase_rank[1] = 5'd1;
    phase_rank[2] = 5'd31;
    phase_rank[3] = 5'd0;
    phase_rank[4] = kthl_pkg::RANK_W'($urandom_range(2, 15));
    phase_rank[5] = kthl_pkg::RANK_W'($urandom_range(0, 31));
    phase_rank[6] = 5'd8;

    for (int p = 0; p < 7; p++) begin
      write_rank(phase_rank[p]);
      if (p < 3) begin
        snd_idle = 28;
        rcv_idle = 62;
      end else if (p < 5) begin
        snd_idle = 62;
        rcv_idle = 28;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      send_random(150);
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/kthl_pkg.sv
hdl/kthl_cell.sv
hdl/streaming_kth_largest_top.sv
tb/streaming_kth_largest_top_tb.sv
